@@ rtl/tptw_pkg.sv @@
// ----------------------------------------------------------------------------
// tptw_pkg: shared types, constants and microcode for the two-wheel
// trapezoidal setpoint generator.
// Holds the command codes, the register map, the datapath widths and the
// control program that the sequencer steps through.
// ----------------------------------------------------------------------------
package tptw_pkg;

    // Fixed point format: positions Q24.8, velocities Q16.8.
    localparam int FRAC_BITS = 8;

    // Field and datapath widths.
    localparam int CMD_W      = 3;
    localparam int COUNT_W    = 16;
    localparam int POS_W      = 32;
    localparam int VEL_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MAG_W      = 32;   // |target - position|
    localparam int PROD_W     = 40;   // 24 x 16 multiplier product
    localparam int RAD_W      = 56;   // 2 * max_accel * |error|
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 4;
    localparam int PC_W       = 5;
    localparam int CNT_W      = 5;

    // Register map.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_DISTANCE   = 3'd4;

    // Register values after reset.
    localparam logic [22:0] RST_MAX_VELOCITY     = 23'd12800;
    localparam logic [22:0] RST_MAX_ACCEL        = 23'd25600;
    localparam logic [15:0] RST_TICK_PERIOD      = 16'd655;
    localparam logic [23:0] RST_FORWARD_DISTANCE = 24'd25600;
    localparam logic [23:0] RST_PIVOT_DISTANCE   = 24'd25600;

    // Snap thresholds: error under 1.0 and ten times the speed under 1.0.
    localparam logic [MAG_W-1:0] SNAP_MAG = MAG_W'(1) << FRAC_BITS;
    localparam logic [27:0]      SNAP_V10 = 28'(1) << FRAC_BITS;

    // Half of one Q0.16 step, for round to nearest.
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 15;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_BACK    = 3'd2,
        CMD_LEFT    = 3'd3,
        CMD_RIGHT   = 3'd4,
        CMD_RESET   = 3'd5
    } t_cmd;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Datapath operations, one per control word.
    typedef enum logic [4:0] {
        OP_FINISH,
        OP_CLEAR,
        OP_DRV_MUL,
        OP_DRV_ADD,
        OP_ERR,
        OP_MAG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_RAD,
        OP_SQRT,
        OP_DES,
        OP_VERR,
        OP_VABS,
        OP_VNEW,
        OP_PABS,
        OP_PMUL,
        OP_PSTEP,
        OP_PUPD
    } t_op;

    // Jump conditions.
    typedef enum logic [1:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_CNT_NZ,
        COND_WHEEL_LEFT
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Program addresses.
    localparam logic [PC_W-1:0] ADR_DRIVE    = 5'd0;
    localparam logic [PC_W-1:0] ADR_DRV_ADD  = 5'd1;
    localparam logic [PC_W-1:0] ADR_FINISH_A = 5'd2;
    localparam logic [PC_W-1:0] ADR_CLEAR    = 5'd3;
    localparam logic [PC_W-1:0] ADR_TICK     = 5'd4;
    localparam logic [PC_W-1:0] ADR_SQRT     = 5'd9;
    localparam logic [PC_W-1:0] ADR_FINISH_B = 5'd18;
    localparam int              PROG_LEN     = 19;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control program. A wheel body ends by toggling the wheel select and
    // jumping back while the left wheel was the one just done.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:    w = uw(OP_DRV_MUL, COND_NEXT,       ADR_DRIVE);
            5'd1:    w = uw(OP_DRV_ADD, COND_WHEEL_LEFT, ADR_DRV_ADD);
            5'd2:    w = uw(OP_FINISH,  COND_NEXT,       ADR_FINISH_A);
            5'd3:    w = uw(OP_CLEAR,   COND_ALWAYS,     ADR_FINISH_A);
            5'd4:    w = uw(OP_ERR,     COND_NEXT,       ADR_TICK);
            5'd5:    w = uw(OP_MAG,     COND_NEXT,       ADR_TICK);
            5'd6:    w = uw(OP_MUL_LO,  COND_NEXT,       ADR_TICK);
            5'd7:    w = uw(OP_MUL_HI,  COND_NEXT,       ADR_TICK);
            5'd8:    w = uw(OP_RAD,     COND_NEXT,       ADR_TICK);
            5'd9:    w = uw(OP_SQRT,    COND_CNT_NZ,     ADR_SQRT);
            5'd10:   w = uw(OP_DES,     COND_NEXT,       ADR_TICK);
            5'd11:   w = uw(OP_VERR,    COND_NEXT,       ADR_TICK);
            5'd12:   w = uw(OP_VABS,    COND_NEXT,       ADR_TICK);
            5'd13:   w = uw(OP_VNEW,    COND_NEXT,       ADR_TICK);
            5'd14:   w = uw(OP_PABS,    COND_NEXT,       ADR_TICK);
            5'd15:   w = uw(OP_PMUL,    COND_NEXT,       ADR_TICK);
            5'd16:   w = uw(OP_PSTEP,   COND_NEXT,       ADR_TICK);
            5'd17:   w = uw(OP_PUPD,    COND_WHEEL_LEFT, ADR_TICK);
            5'd18:   w = uw(OP_FINISH,  COND_NEXT,       ADR_FINISH_B);
            default: w = uw(OP_FINISH,  COND_NEXT,       ADR_FINISH_B);
        endcase
        return w;
    endfunction

    // Program entry point for each command code.
    function automatic logic [PC_W-1:0] entry(input logic [CMD_W-1:0] cmd);
        logic [PC_W-1:0] adr;
        case (t_cmd'(cmd))
            CMD_TICK:    adr = ADR_TICK;
            CMD_FORWARD: adr = ADR_DRIVE;
            CMD_BACK:    adr = ADR_DRIVE;
            CMD_LEFT:    adr = ADR_DRIVE;
            CMD_RIGHT:   adr = ADR_DRIVE;
            CMD_RESET:   adr = ADR_CLEAR;
            default:     adr = ADR_FINISH_A;
        endcase
        return adr;
    endfunction

    // Saturate a wide two's complement sum to 32 bits signed.
    function automatic logic [POS_W-1:0] sat32(input logic [40:0] v);
        logic [POS_W-1:0] r;
        if (!v[40] && (|v[39:31])) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v[40] && !(&v[39:31])) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/tptw_if.sv @@
// ----------------------------------------------------------------------------
// tptw_if: channel interfaces of the two-wheel setpoint generator.
// tptw_cmd_if carries commands in, tptw_res_if carries setpoint results out.
// Both use valid/ready; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface tptw_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [tptw_pkg::CMD_W-1:0]          command;
    logic signed [tptw_pkg::COUNT_W-1:0] count;

    modport source (output valid, output command, output count, input ready);
    modport sink   (input valid, input command, input count, output ready);
endinterface

interface tptw_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [tptw_pkg::POS_W-1:0] left_position_setpoint;
    logic signed [tptw_pkg::POS_W-1:0] right_position_setpoint;
    logic signed [tptw_pkg::VEL_W-1:0] left_velocity_setpoint;
    logic signed [tptw_pkg::VEL_W-1:0] right_velocity_setpoint;

    modport source (output valid, output left_position_setpoint,
                    output right_position_setpoint, output left_velocity_setpoint,
                    output right_velocity_setpoint, input ready);
    modport sink   (input valid, input left_position_setpoint,
                    input right_position_setpoint, input left_velocity_setpoint,
                    input right_velocity_setpoint, output ready);
endinterface

@@ rtl/trapezoidal_profile_two_wheel.sv @@
// ----------------------------------------------------------------------------
// trapezoidal_profile_two_wheel: two-wheel trapezoidal setpoint generator.
// A microcoded sequencer steps a small fixed point datapath (one 24x16
// multiplier, a bit-serial square root, add/compare units) through the drive,
// reset and tick programs held in the package.
//
//   Channel   Dir  Payload                                   Handshake
//   i_cmd     in   command, count                            valid/ready
//   o_res     out  left/right position, left/right velocity  valid/ready
//   i_cfg_*   in   register index, write data                write enable
//
// In a tick the bit-serial square root runs 28 iterations per wheel, one per
// root bit; drive, reset and unused command codes run much shorter programs.
// Commands are taken only while the sequencer is idle; a result waits in the
// output register, and the sequencer stalls on its last step only while that
// register is still full. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module trapezoidal_profile_two_wheel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tptw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tptw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    tptw_cmd_if.sink                            i_cmd,
    tptw_res_if.source                          o_res
);

    // Configuration registers.
    logic [22:0] r_max_vel;
    logic [22:0] r_max_acc;
    logic [15:0] r_tick_per;
    logic [23:0] r_fwd_dist;
    logic [23:0] r_piv_dist;

    // Wheel state.
    logic [tptw_pkg::POS_W-1:0] r_ltgt, r_rtgt, r_lpos, r_rpos;
    logic [tptw_pkg::VEL_W-1:0] r_lvel, r_rvel;

    // Sequencer.
    tptw_pkg::t_state            r_state, n_state;
    logic [tptw_pkg::PC_W-1:0]   r_pc, n_pc;
    logic [tptw_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_wheel;
    tptw_pkg::t_uword            w_uw;
    tptw_pkg::t_op               w_op;
    logic                        w_run;
    logic                        w_out_free;
    logic                        w_taken;

    // Latched command.
    logic [tptw_pkg::CMD_W-1:0]   r_cmd;
    logic [tptw_pkg::COUNT_W-1:0] r_count;

    // Datapath registers.
    logic [32:0]                  r_err;
    logic [tptw_pkg::MAG_W-1:0]   r_mag;
    logic [tptw_pkg::PROD_W-1:0]  r_prod;
    logic [38:0]                  r_acc;
    logic [tptw_pkg::RAD_W-1:0]   r_rad;
    logic [tptw_pkg::REM_W-1:0]   r_rem;
    logic [tptw_pkg::ROOT_W-1:0]  r_root;
    logic [23:0]                  r_des;
    logic [24:0]                  r_verr;
    logic [38:0]                  r_limf;
    logic [24:0]                  r_vmag;
    logic [23:0]                  r_v;
    logic [23:0]                  r_pv;
    logic [23:0]                  r_stepm;

    // Output register.
    logic                         r_out_valid;
    logic [tptw_pkg::POS_W-1:0]   r_out_lpos, r_out_rpos;
    logic [tptw_pkg::VEL_W-1:0]   r_out_lvel, r_out_rvel;

    // Datapath wires.
    logic [tptw_pkg::POS_W-1:0]   w_tgt, w_pos;
    logic [tptw_pkg::VEL_W-1:0]   w_vel;
    logic [23:0]                  w_mul_a;
    logic [15:0]                  w_mul_b;
    logic [tptw_pkg::PROD_W-1:0]  w_mul_p;
    logic [15:0]                  w_cnt_abs;
    logic                         w_drv_fwd;
    logic                         w_drv_sub;
    logic                         w_drv_neg;
    logic [40:0]                  w_tsum;
    logic [32:0]                  w_err_neg;
    logic [54:0]                  w_rsum;
    logic [tptw_pkg::REM_W-1:0]   w_rem_sh;
    logic [tptw_pkg::REM_W-1:0]   w_trial;
    logic                         w_ge;
    logic [22:0]                  w_want;
    logic [23:0]                  w_want_x;
    logic [24:0]                  w_verr_neg;
    logic                         w_clamp;
    logic [24:0]                  w_vlim;
    logic [23:0]                  w_v_neg;
    logic [tptw_pkg::PROD_W-1:0]  w_round;
    logic [40:0]                  w_psum;
    logic [27:0]                  w_pv10;
    logic                         w_snap;
    logic                         w_load;

    // Current control word and handshake status.
    assign w_uw       = tptw_pkg::ucode(r_pc);
    assign w_op       = w_uw.op;
    assign w_run      = (r_state == tptw_pkg::S_RUN);
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_load     = w_run && (w_op == tptw_pkg::OP_FINISH) && w_out_free;

    assign i_cmd.ready = (r_state == tptw_pkg::S_IDLE);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel  <= tptw_pkg::RST_MAX_VELOCITY;
            r_max_acc  <= tptw_pkg::RST_MAX_ACCEL;
            r_tick_per <= tptw_pkg::RST_TICK_PERIOD;
            r_fwd_dist <= tptw_pkg::RST_FORWARD_DISTANCE;
            r_piv_dist <= tptw_pkg::RST_PIVOT_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tptw_pkg::CFG_MAX_VELOCITY:     r_max_vel  <= i_cfg_data[22:0];
                tptw_pkg::CFG_MAX_ACCEL:        r_max_acc  <= i_cfg_data[22:0];
                tptw_pkg::CFG_TICK_PERIOD:      r_tick_per <= i_cfg_data[15:0];
                tptw_pkg::CFG_FORWARD_DISTANCE: r_fwd_dist <= i_cfg_data;
                tptw_pkg::CFG_PIVOT_DISTANCE:   r_piv_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tptw_pkg::S_IDLE;
            r_pc    <= tptw_pkg::ADR_FINISH_A;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Next state and program counter.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        w_taken = 1'b0;
        case (w_uw.cond)
            tptw_pkg::COND_NEXT:       w_taken = 1'b0;
            tptw_pkg::COND_ALWAYS:     w_taken = 1'b1;
            tptw_pkg::COND_CNT_NZ:     w_taken = (r_cnt != '0);
            tptw_pkg::COND_WHEEL_LEFT: w_taken = !r_wheel;
            default:                   w_taken = 1'b0;
        endcase
        case (r_state)
            tptw_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = tptw_pkg::S_RUN;
                    n_pc    = tptw_pkg::entry(i_cmd.command);
                end
            end
            tptw_pkg::S_RUN: begin
                if (w_op == tptw_pkg::OP_FINISH) begin
                    if (w_out_free) begin
                        n_state = tptw_pkg::S_IDLE;
                    end
                end else begin
                    n_pc = w_taken ? w_uw.target : r_pc + 1'b1;
                end
            end
            default: n_state = tptw_pkg::S_IDLE;
        endcase
    end

    // Wheel select and iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_wheel <= 1'b0;
        end else if (w_run) begin
            case (w_op)
                tptw_pkg::OP_DRV_ADD: r_wheel <= !r_wheel;
                tptw_pkg::OP_PUPD:    r_wheel <= !r_wheel;
                tptw_pkg::OP_RAD:     r_cnt   <= tptw_pkg::CNT_W'(tptw_pkg::ROOT_W - 1);
                tptw_pkg::OP_SQRT:    r_cnt   <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    // Command capture on transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd   <= i_cmd.command;
            r_count <= i_cmd.count;
        end
    end

    // Selected wheel.
    assign w_tgt = r_wheel ? r_rtgt : r_ltgt;
    assign w_pos = r_wheel ? r_rpos : r_lpos;
    assign w_vel = r_wheel ? r_rvel : r_lvel;

    // Shared multiplier operand selection.
    always_comb begin
        w_cnt_abs = r_count[15] ? 16'(-r_count) : r_count;
        w_drv_fwd = (r_cmd inside {tptw_pkg::CMD_FORWARD, tptw_pkg::CMD_BACK});
        w_mul_a   = '0;
        w_mul_b   = '0;
        case (w_op)
            tptw_pkg::OP_DRV_MUL: begin
                w_mul_a = w_drv_fwd ? r_fwd_dist : r_piv_dist;
                w_mul_b = w_cnt_abs;
            end
            tptw_pkg::OP_MUL_LO: begin
                w_mul_a = {1'b0, r_max_acc};
                w_mul_b = r_mag[15:0];
            end
            tptw_pkg::OP_MUL_HI: begin
                w_mul_a = {1'b0, r_max_acc};
                w_mul_b = r_mag[31:16];
            end
            tptw_pkg::OP_DES: begin
                w_mul_a = {1'b0, r_max_acc};
                w_mul_b = r_tick_per;
            end
            tptw_pkg::OP_PMUL: begin
                w_mul_a = r_pv;
                w_mul_b = r_tick_per;
            end
            default: ;
        endcase
        w_mul_p = w_mul_a * w_mul_b;
    end

    // Target step: the sign follows the command, the wheel and the count.
    always_comb begin
        if (r_wheel) begin
            w_drv_sub = (r_cmd inside {tptw_pkg::CMD_BACK, tptw_pkg::CMD_RIGHT});
        end else begin
            w_drv_sub = (r_cmd inside {tptw_pkg::CMD_BACK, tptw_pkg::CMD_LEFT});
        end
        w_drv_neg = w_drv_sub ^ r_count[15];
        if (w_drv_neg) begin
            w_tsum = {{9{w_tgt[31]}}, w_tgt} - {1'b0, r_prod};
        end else begin
            w_tsum = {{9{w_tgt[31]}}, w_tgt} + {1'b0, r_prod};
        end
    end

    // Tick arithmetic.
    always_comb begin
        w_err_neg  = -r_err;
        w_rsum     = {16'b0, r_acc} + {r_prod[38:0], 16'b0};

        // One root bit per step: shift in two radicand bits, try 4*root+1.
        w_rem_sh   = {r_rem[tptw_pkg::REM_W-3:0], r_rad[tptw_pkg::RAD_W-1 -: 2]};
        w_trial    = {2'b00, r_root, 2'b01};
        w_ge       = (w_rem_sh >= w_trial);

        // Desired speed is the lesser of the limit and the stopping speed.
        w_want     = ({5'b0, r_max_vel} < r_root) ? r_max_vel : r_root[22:0];
        w_want_x   = {1'b0, w_want};

        w_verr_neg = -r_verr;

        // Clamp the speed change only when it exceeds max_accel*tick_period.
        w_clamp    = ({r_vmag, 16'b0} > {2'b0, r_limf});
        if (r_verr[24]) begin
            w_vlim = {w_vel[23], w_vel} - {2'b0, r_limf[38:16]};
        end else begin
            w_vlim = {w_vel[23], w_vel} + {2'b0, r_limf[38:16]};
        end

        w_v_neg    = -r_v;
        w_round    = r_prod + tptw_pkg::ROUND_HALF;

        if (r_v[23]) begin
            w_psum = {{9{w_pos[31]}}, w_pos} - {17'b0, r_stepm};
        end else begin
            w_psum = {{9{w_pos[31]}}, w_pos} + {17'b0, r_stepm};
        end

        // Close and slow: snap onto the target.
        w_pv10 = 28'({r_pv, 3'b000}) + 28'({r_pv, 1'b0});
        w_snap = (r_mag < tptw_pkg::SNAP_MAG) && (w_pv10 < tptw_pkg::SNAP_V10);
    end

    // Datapath registers, loaded by the current control word.
    always_ff @(posedge i_clk) begin
        if (w_run) begin
            case (w_op)
                tptw_pkg::OP_DRV_MUL: r_prod <= w_mul_p;
                tptw_pkg::OP_ERR: begin
                    r_err <= {w_tgt[31], w_tgt} - {w_pos[31], w_pos};
                end
                tptw_pkg::OP_MAG: begin
                    r_mag <= r_err[32] ? w_err_neg[31:0] : r_err[31:0];
                end
                tptw_pkg::OP_MUL_LO: r_prod <= w_mul_p;
                tptw_pkg::OP_MUL_HI: begin
                    r_prod <= w_mul_p;
                    r_acc  <= r_prod[38:0];
                end
                tptw_pkg::OP_RAD: begin
                    r_rad  <= {w_rsum, 1'b0};
                    r_rem  <= '0;
                    r_root <= '0;
                end
                tptw_pkg::OP_SQRT: begin
                    r_rem  <= w_ge ? w_rem_sh - w_trial : w_rem_sh;
                    r_root <= {r_root[tptw_pkg::ROOT_W-2:0], w_ge};
                    r_rad  <= {r_rad[tptw_pkg::RAD_W-3:0], 2'b00};
                end
                tptw_pkg::OP_DES: begin
                    r_des  <= r_err[32] ? -w_want_x : w_want_x;
                    r_prod <= w_mul_p;
                end
                tptw_pkg::OP_VERR: begin
                    r_verr <= {r_des[23], r_des} - {w_vel[23], w_vel};
                    r_limf <= r_prod[38:0];
                end
                tptw_pkg::OP_VABS: r_vmag <= r_verr[24] ? w_verr_neg : r_verr;
                tptw_pkg::OP_VNEW: r_v <= w_clamp ? w_vlim[23:0] : r_des;
                tptw_pkg::OP_PABS: r_pv <= r_v[23] ? w_v_neg : r_v;
                tptw_pkg::OP_PMUL: r_prod <= w_mul_p;
                tptw_pkg::OP_PSTEP: r_stepm <= w_round[39:16];
                default: ;
            endcase
        end
    end

    // Wheel state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ltgt <= '0;
            r_rtgt <= '0;
            r_lpos <= '0;
            r_rpos <= '0;
            r_lvel <= '0;
            r_rvel <= '0;
        end else if (w_run) begin
            case (w_op)
                tptw_pkg::OP_CLEAR: begin
                    r_ltgt <= '0;
                    r_rtgt <= '0;
                    r_lpos <= '0;
                    r_rpos <= '0;
                    r_lvel <= '0;
                    r_rvel <= '0;
                end
                tptw_pkg::OP_DRV_ADD: begin
                    if (r_wheel) begin
                        r_rtgt <= tptw_pkg::sat32(w_tsum);
                    end else begin
                        r_ltgt <= tptw_pkg::sat32(w_tsum);
                    end
                end
                tptw_pkg::OP_PUPD: begin
                    if (r_wheel) begin
                        r_rpos <= w_snap ? r_rtgt : tptw_pkg::sat32(w_psum);
                        r_rvel <= w_snap ? '0 : r_v;
                    end else begin
                        r_lpos <= w_snap ? r_ltgt : tptw_pkg::sat32(w_psum);
                        r_lvel <= w_snap ? '0 : r_v;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: loaded on the last step, freed by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_lpos <= r_lpos;
            r_out_rpos <= r_rpos;
            r_out_lvel <= r_lvel;
            r_out_rvel <= r_rvel;
        end
    end

    assign o_res.valid                   = r_out_valid;
    assign o_res.left_position_setpoint  = r_out_lpos;
    assign o_res.right_position_setpoint = r_out_rpos;
    assign o_res.left_velocity_setpoint  = r_out_lvel;
    assign o_res.right_velocity_setpoint = r_out_rvel;

    // A transfer always starts the program.
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state == tptw_pkg::S_RUN))
        else $error("command transfer did not start the sequencer");

    // The program counter stays inside the control program.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc < tptw_pkg::PC_W'(tptw_pkg::PROG_LEN)))
        else $error("program counter left the control program");

    // The last step loads the output register and returns to idle.
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == tptw_pkg::S_IDLE) && r_out_valid)
        else $error("last step did not load the result");

    // The square root remainder never needs its two top bits.
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_run && (w_op == tptw_pkg::OP_SQRT))
            |-> (r_rem[tptw_pkg::REM_W-1 -: 2] == 2'b00))
        else $error("square root remainder overflowed");

endmodule

@@ verif/tptw_setpoint_monitor.sv @@
// ----------------------------------------------------------------------------
// tptw_setpoint_monitor: setpoint predictor and result checker
// Watches the command, result and register write ports of the two-wheel
// trapezoidal setpoint generator. It keeps its own copy of the wheel state
// and of the registers, predicts the setpoints after each command transfer,
// and compares every result transfer field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tptw_setpoint_monitor
    import tptw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tptw_cmd_if                   i_cmd,
    tptw_res_if                   i_res,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic signed [POS_W-1:0] left_pos;
        logic signed [POS_W-1:0] right_pos;
        logic signed [VEL_W-1:0] left_vel;
        logic signed [VEL_W-1:0] right_vel;
    } t_setpoint;

    // Register copies.
    longint unsigned vmax_reg;
    longint unsigned accel_reg;
    longint unsigned period_reg;
    longint unsigned fwd_dist_reg;
    longint unsigned pivot_dist_reg;

    // Wheel state, kept wide so that sums never wrap before saturation.
    longint tgt_l, tgt_r, pos_l, pos_r, vel_l, vel_r;

    t_setpoint setpoints_due[$];
    int        fail_total = 0;
    int        checked_total = 0;
    int        pending_due = 0;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;
    assign o_pending    = pending_due;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Floor square root, one result bit at a time from the top.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // One control period for one wheel: pick the speed that still allows a
    // stop at the target, limit the change of speed, integrate, then snap.
    task automatic advance_wheel(input longint target, inout longint pos,
                                 inout longint vel);
        longint          err, desired, verr, v, step;
        longint unsigned mag, want, vmag, accel_dt, speed, step_mag;
        err  = target - pos;
        mag  = (err < 0) ? -err : err;
        want = floor_sqrt(2 * accel_reg * mag);
        if (vmax_reg < want) begin
            want = vmax_reg;
        end
        desired  = (err < 0) ? -longint'(want) : longint'(want);
        verr     = desired - vel;
        vmag     = (verr < 0) ? -verr : verr;
        accel_dt = accel_reg * period_reg;
        if ((vmag << 16) > accel_dt) begin
            v = vel + ((verr > 0) ? longint'(accel_dt >> 16) : -longint'(accel_dt >> 16));
        end else begin
            v = desired;
        end
        // Position step rounds to nearest, ties away from zero.
        speed    = (v < 0) ? -v : v;
        step_mag = (speed * period_reg + 64'd32768) >> 16;
        step     = (v < 0) ? -longint'(step_mag) : longint'(step_mag);
        pos      = clamp32(pos + step);
        vel      = v;
        if (mag < (64'd1 << FRAC_BITS) && speed * 10 < (64'd1 << FRAC_BITS)) begin
            pos = target;
            vel = 0;
        end
    endtask

    task automatic run_command(input logic [CMD_W-1:0] code,
                               input logic signed [COUNT_W-1:0] cnt);
        longint fwd, piv;
        fwd = longint'(cnt) * longint'(fwd_dist_reg);
        piv = longint'(cnt) * longint'(pivot_dist_reg);
        case (code)
            CMD_TICK: begin
                advance_wheel(tgt_l, pos_l, vel_l);
                advance_wheel(tgt_r, pos_r, vel_r);
            end
            CMD_FORWARD: begin
                tgt_l = clamp32(tgt_l + fwd);
                tgt_r = clamp32(tgt_r + fwd);
            end
            CMD_BACK: begin
                tgt_l = clamp32(tgt_l - fwd);
                tgt_r = clamp32(tgt_r - fwd);
            end
            CMD_LEFT: begin
                tgt_l = clamp32(tgt_l - piv);
                tgt_r = clamp32(tgt_r + piv);
            end
            CMD_RIGHT: begin
                tgt_l = clamp32(tgt_l + piv);
                tgt_r = clamp32(tgt_r - piv);
            end
            CMD_RESET: begin
                tgt_l = 0;
                tgt_r = 0;
                pos_l = 0;
                pos_r = 0;
                vel_l = 0;
                vel_r = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic flag_failure(input string msg);
        fail_total++;
        $error("%s", msg);
    endtask

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got) begin
            flag_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
        end
    endtask

    // Everything is sampled at the rising edge, where the block samples too.
    always @(posedge i_clk) begin : track
        t_setpoint due;
        if (!i_rst_n) begin
            vmax_reg       = RST_MAX_VELOCITY;
            accel_reg      = RST_MAX_ACCEL;
            period_reg     = RST_TICK_PERIOD;
            fwd_dist_reg   = RST_FORWARD_DISTANCE;
            pivot_dist_reg = RST_PIVOT_DISTANCE;
            tgt_l = 0;
            tgt_r = 0;
            pos_l = 0;
            pos_r = 0;
            vel_l = 0;
            vel_r = 0;
            setpoints_due.delete();
        end else begin
            // Result transfer: check against the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                if (setpoints_due.size() == 0) begin
                    flag_failure("result transfer with no prediction waiting");
                end else begin
                    due = setpoints_due.pop_front();
                    compare_field("left_position_setpoint", due.left_pos,
                                  i_res.left_position_setpoint);
                    compare_field("right_position_setpoint", due.right_pos,
                                  i_res.right_position_setpoint);
                    compare_field("left_velocity_setpoint", due.left_vel,
                                  i_res.left_velocity_setpoint);
                    compare_field("right_velocity_setpoint", due.right_vel,
                                  i_res.right_velocity_setpoint);
                    checked_total++;
                end
            end

            // Register writes, masked to each register's width.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_VELOCITY:     vmax_reg       = i_cfg_data[22:0];
                    CFG_MAX_ACCEL:        accel_reg      = i_cfg_data[22:0];
                    CFG_TICK_PERIOD:      period_reg     = i_cfg_data[15:0];
                    CFG_FORWARD_DISTANCE: fwd_dist_reg   = i_cfg_data[23:0];
                    CFG_PIVOT_DISTANCE:   pivot_dist_reg = i_cfg_data[23:0];
                    default: begin
                    end
                endcase
            end

            // Command transfer: every command yields exactly one result.
            if (i_cmd.valid && i_cmd.ready) begin
                run_command(i_cmd.command, i_cmd.count);
                due.left_pos  = pos_l[POS_W-1:0];
                due.right_pos = pos_r[POS_W-1:0];
                due.left_vel  = vel_l[VEL_W-1:0];
                due.right_vel = vel_r[VEL_W-1:0];
                setpoints_due.push_back(due);
            end
        end
        pending_due <= setpoints_due.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the two-wheel trapezoidal setpoint generator
// Drives a short directed command list, then random drive-and-tick sequences
// under a series of register settings, with bursty command traffic and a
// stalling result receiver. Prediction and checking live in the monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tptw_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 100;

    // Command codes that the block does not decode.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [CFG_DATA_W-1:0] VMAX_TOP   = 24'h7F_FFFF;
    localparam logic [CFG_DATA_W-1:0] ACCEL_TOP  = 24'h7F_FFFF;
    localparam logic [CFG_DATA_W-1:0] PERIOD_TOP = 24'h00_FFFF;
    localparam logic [CFG_DATA_W-1:0] DIST_TOP   = 24'hFF_FFFF;

    typedef enum int {
        SET_LIVELY,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_CORNERS,
        SET_RANDOM
    } t_setting;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tptw_cmd_if cmd_ch();
    tptw_res_if res_ch();

    int fail_count;
    int pending;
    int checked;

    int cycles = 0;
    int burst_left = 1;
    int count_span = 12;
    int n_items = 0;
    int n_ticks = 0;
    int n_drives = 0;
    int n_clears = 0;
    int n_spare = 0;
    int n_settings = 0;

    trapezoidal_profile_two_wheel dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    tptw_setpoint_monitor u_setpoint_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: watchdog expired after %0d cycles", cycles);
        $display("tb_top: done, errors");
        $finish;
    end

    // Result receiver: alternating spans of always ready, random stalls and
    // a regular stall pattern.
    initial begin
        int mode, span, low_len, period;
        res_ch.ready <= 1'b0;
        forever begin
            mode    = $urandom_range(0, 2);
            span    = $urandom_range(50, 400);
            low_len = $urandom_range(1, 8);
            period  = low_len + $urandom_range(1, 8);
            for (int c = 0; c < span; c++) begin
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 9) < 6);
                    default: res_ch.ready <= ((c % period) >= low_len);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Offer one command and hold it until its transfer. Within a burst the
    // valid stays high into the next command; a burst ends with a gap.
    task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [COUNT_W-1:0] cnt);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= code;
        cmd_ch.count   <= cnt;
        @(posedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
        end
        n_items++;
        case (code)
            CMD_TICK:  n_ticks++;
            CMD_RESET: n_clears++;
            CMD_SPARE_LO, CMD_SPARE_HI: n_spare++;
            default:   n_drives++;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            cmd_ch.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                burst_left = $urandom_range(100, 300);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Stop offering commands and wait until every result has come back.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [CFG_DATA_W-1:0] vmax, accel, period,
                                   fwd, piv);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idx  [5];
        vals = '{vmax, accel, period, fwd, piv};
        idx  = '{CFG_MAX_VELOCITY, CFG_MAX_ACCEL, CFG_TICK_PERIOD,
                 CFG_FORWARD_DISTANCE, CFG_PIVOT_DISTANCE};
        for (int r = 0; r < 5; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Choose a register setting and the range of drive counts that suits it.
    task automatic apply_setting(input t_setting kind);
        logic [CFG_DATA_W-1:0] vmax, accel, period, fwd, piv;
        case (kind)
            SET_LIVELY: begin
                // Short moves that finish within a few dozen ticks.
                vmax       = CFG_DATA_W'($urandom_range(256, 8192));
                accel      = CFG_DATA_W'($urandom_range(256, 16384));
                period     = CFG_DATA_W'($urandom_range(3000, 20000));
                fwd        = CFG_DATA_W'($urandom_range(16, 2048));
                piv        = CFG_DATA_W'($urandom_range(16, 2048));
                count_span = 12;
            end
            SET_ALL_MAX: begin
                vmax       = VMAX_TOP;
                accel      = ACCEL_TOP;
                period     = PERIOD_TOP;
                fwd        = DIST_TOP;
                piv        = DIST_TOP;
                count_span = 32767;
            end
            SET_ALL_MIN: begin
                vmax       = '0;
                accel      = '0;
                period     = 24'd1;
                fwd        = '0;
                piv        = '0;
                count_span = 100;
            end
            SET_CORNERS: begin
                vmax       = $urandom_range(0, 1) ? VMAX_TOP : '0;
                accel      = $urandom_range(0, 1) ? ACCEL_TOP : '0;
                period     = $urandom_range(0, 1) ? PERIOD_TOP : 24'd1;
                fwd        = $urandom_range(0, 1) ? DIST_TOP : '0;
                piv        = $urandom_range(0, 1) ? DIST_TOP : '0;
                count_span = 32767;
            end
            default: begin
                vmax       = CFG_DATA_W'($urandom_range(0, 24'h7F_FFFF));
                accel      = CFG_DATA_W'($urandom_range(0, 24'h7F_FFFF));
                period     = CFG_DATA_W'($urandom_range(1, 24'h00_FFFF));
                fwd        = CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF));
                piv        = CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF));
                count_span = $urandom_range(1, 32767);
            end
        endcase
        write_registers(vmax, accel, period, fwd, piv);
    endtask

    function automatic logic [COUNT_W-1:0] drive_count();
        int                  pick;
        logic [COUNT_W-1:0]  mag;
        pick = $urandom_range(0, 19);
        mag  = COUNT_W'($urandom_range(1, count_span));
        if (pick == 0) begin
            return 16'h8000;
        end else if (pick == 1) begin
            return 16'h7FFF;
        end else if (pick == 2) begin
            return '0;
        end else if (pick == 3) begin
            return COUNT_W'($urandom);
        end
        return pick[0] ? -mag : mag;
    endfunction

    // One random stretch of traffic. Most are a drive command followed by
    // enough ticks for the wheels to move toward the new targets.
    task automatic random_stretch();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
            send_cmd(CMD_W'($urandom_range(CMD_FORWARD, CMD_RIGHT)), drive_count());
            repeat ($urandom_range(4, 40)) send_cmd(CMD_TICK, COUNT_W'($urandom));
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 10)) send_cmd(CMD_TICK, COUNT_W'($urandom));
        end else if (pick < 86) begin
            send_cmd(CMD_RESET, COUNT_W'($urandom));
        end else if (pick < 91) begin
            send_cmd($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO, COUNT_W'($urandom));
        end else if (pick < 97) begin
            send_cmd(CMD_W'($urandom_range(CMD_FORWARD, CMD_RIGHT)), COUNT_W'($urandom));
        end else begin
            settle();
        end
    endtask

    initial begin
        int       base, phase_end, phase;
        t_setting kind;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_MAX_VELOCITY;
        i_cfg_data     <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_TICK;
        cmd_ch.count   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings: every command, count
        // extremes, undecoded codes, target saturation and a clear.
        send_cmd(CMD_TICK, 16'h7FFF);
        send_cmd(CMD_FORWARD, 16'h0001);
        send_cmd(CMD_TICK, 16'h8000);
        send_cmd(CMD_TICK, 16'h0000);
        send_cmd(CMD_BACK, 16'h8000);
        send_cmd(CMD_TICK, 16'hFFFF);
        send_cmd(CMD_LEFT, 16'h7FFF);
        send_cmd(CMD_RIGHT, 16'hFFFF);
        send_cmd(CMD_SPARE_LO, 16'hAAAA);
        send_cmd(CMD_SPARE_HI, 16'h5555);
        send_cmd(CMD_RESET, 16'h1234);
        send_cmd(CMD_FORWARD, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000);
        send_cmd(CMD_FORWARD, 16'h7FFF);
        send_cmd(CMD_FORWARD, 16'h7FFF);
        send_cmd(CMD_FORWARD, 16'h7FFF);
        send_cmd(CMD_TICK, 16'h0000);

        // Zero speed limit, zero acceleration and zero tick period, with the
        // largest distances driving both targets into saturation.
        settle();
        write_registers('0, '0, '0, DIST_TOP, DIST_TOP);
        send_cmd(CMD_RESET, 16'h0000);
        send_cmd(CMD_BACK, 16'h7FFF);
        send_cmd(CMD_TICK, 16'h0000);
        send_cmd(CMD_LEFT, 16'h8000);
        send_cmd(CMD_TICK, 16'h0000);

        // Random part, one register setting per phase.
        base  = n_items;
        phase = 0;
        while (n_items - base < RANDOM_ITEMS) begin
            phase++;
            case (phase)
                1: kind = SET_ALL_MAX;
                2: kind = SET_ALL_MIN;
                3: kind = SET_CORNERS;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: kind = SET_LIVELY;
                        5:             kind = SET_ALL_MAX;
                        6:             kind = SET_CORNERS;
                        default:       kind = SET_RANDOM;
                    endcase
                end
            endcase
            settle();
            apply_setting(kind);
            phase_end = n_items + $urandom_range(120, 220);
            while (n_items < phase_end && n_items - base < RANDOM_ITEMS) begin
                random_stretch();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d commands (%0d ticks, %0d drives, %0d clears, %0d undecoded)",
                 n_items, n_ticks, n_drives, n_clears, n_spare);
        $display("tb_top: %0d results checked over %0d register settings, %0d failures",
                 checked, n_settings, fail_count);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
